### hw/rtl/mm_pkg.sv
// Shared constants, types and helpers for the fixed-point matrix multiply.
// No dependencies; imported by mm_cfg, mm_ctrl, mm_dpath and matrix_multiply.
`default_nettype none

package mm_pkg;

  localparam int unsigned MAX_DIM = 8;
  localparam int unsigned DIM_W   = 4;                    // size register width
  localparam int unsigned IDX_W   = $clog2(MAX_DIM);      // row / column / inner index
  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;    // entries per store
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = ADDR_W + 1;           // counts reach DEPTH
  localparam int unsigned VAL_W   = 16;                   // Q8.8 element
  localparam int unsigned PROD_W  = 2 * VAL_W;            // Q16.16 product
  localparam int unsigned SUM_W   = 35;                   // Q19.16 sum
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // register indexes (word address)
  typedef enum logic [1:0] {
    REG_ROWS_M  = 2'd0,
    REG_COLS_N  = 2'd1,
    REG_INNER_K = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  // effective sizes, each 1..MAX_DIM
  typedef struct packed {
    logic [DIM_W-1:0] m;
    logic [DIM_W-1:0] n;
    logic [DIM_W-1:0] k;
  } dims_t;

  // one store write plus the compute launch
  typedef struct packed {
    logic              a_we;
    logic              b_we;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
    logic              go;
  } load_t;

  // map a raw size register onto the legal range
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
    logic [DIM_W-1:0] res;
    if (r == '0) begin
      res = DIM_W'(1);
    end else if (r > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = r;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mm_cfg.sv
// APB-style register file for the three size registers.
// Depends on mm_pkg; hands clamped sizes to the load and compute logic.
`default_nettype none

module mm_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mm_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mm_pkg::PDATA_W-1:0]  pwdata,
  output logic      [mm_pkg::PDATA_W-1:0]  prdata,
  output logic                             pready,
  output mm_pkg::dims_t                    dims_o
);
  import mm_pkg::*;

  logic [DIM_W-1:0] rows_q, cols_q, inner_q;
  reg_idx_e         idx;
  logic             wr_en;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // write the addressed size register, drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_W'(MAX_DIM);
      cols_q  <= DIM_W'(MAX_DIM);
      inner_q <= DIM_W'(MAX_DIM);
    end else if (wr_en) begin
      unique case (idx)
        REG_ROWS_M:  rows_q  <= pwdata[DIM_W-1:0];
        REG_COLS_N:  cols_q  <= pwdata[DIM_W-1:0];
        REG_INNER_K: inner_q <= pwdata[DIM_W-1:0];
        default:     ;
      endcase
    end
  end

  // read back the raw register values
  always_comb begin
    unique case (idx)
      REG_ROWS_M:  prdata = PDATA_W'(rows_q);
      REG_COLS_N:  prdata = PDATA_W'(cols_q);
      REG_INNER_K: prdata = PDATA_W'(inner_q);
      default:     prdata = '0;
    endcase
  end

  assign dims_o.m = eff_dim(rows_q);
  assign dims_o.n = eff_dim(cols_q);
  assign dims_o.k = eff_dim(inner_q);

endmodule

`default_nettype wire

### hw/rtl/mm_ctrl.sv
// Load control: element counts, store write requests, completion check, busy.
// Depends on mm_pkg; drives the store writes of mm_dpath.
`default_nettype none

module mm_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      mode_i,
  input  wire logic [mm_pkg::VAL_W-1:0]  value_i,
  input  mm_pkg::dims_t                  dims_i,
  input  wire logic                      done_i,
  output mm_pkg::load_t                  load_o
);
  import mm_pkg::*;

  logic [CNT_W-1:0] a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic [CNT_W-1:0] a_size, b_size, a_next, b_next;
  logic             busy_q, busy_d;
  logic             accept, load_a, load_b, trigger;
  logic [2*DIM_W-1:0] a_prod, b_prod;

  assign a_prod = dims_i.m * dims_i.k;
  assign b_prod = dims_i.k * dims_i.n;
  assign a_size = a_prod[CNT_W-1:0];
  assign b_size = b_prod[CNT_W-1:0];

  assign accept = start && !busy_q;
  assign load_a = accept && !mode_i && (a_cnt_q < a_size);
  assign load_b = accept &&  mode_i && (b_cnt_q < b_size);
  assign a_next = a_cnt_q + CNT_W'(load_a);
  assign b_next = b_cnt_q + CNT_W'(load_b);

  // launch the multiply once both matrices are complete
  assign trigger = accept && (a_next >= a_size) && (b_next >= b_size);

  always_comb begin
    a_cnt_d = trigger ? '0 : a_next;
    b_cnt_d = trigger ? '0 : b_next;
    busy_d  = busy_q;
    if (trigger) begin
      busy_d = 1'b1;
    end else if (done_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      a_cnt_q <= a_cnt_d;
      b_cnt_q <= b_cnt_d;
      busy_q  <= busy_d;
    end
  end

  assign busy        = busy_q;
  assign load_o.a_we = load_a;
  assign load_o.b_we = load_b;
  assign load_o.addr = mode_i ? b_cnt_q[ADDR_W-1:0] : a_cnt_q[ADDR_W-1:0];
  assign load_o.data = value_i;
  assign load_o.go   = trigger;

endmodule

`default_nettype wire

### hw/rtl/mm_dpath.sv
// Element stores and the multiply-accumulate pipeline with its index sequencer.
// Depends on mm_pkg; takes writes and the launch from mm_ctrl.
`default_nettype none

module mm_dpath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  mm_pkg::load_t                  load_i,
  input  mm_pkg::dims_t                  dims_i,
  output logic                           result_valid_o,
  output logic [mm_pkg::SUM_W-1:0]       sum_o,
  output logic [mm_pkg::IDX_W-1:0]       row_o,
  output logic [mm_pkg::IDX_W-1:0]       col_o,
  output logic                           last_o,
  output logic                           done_o
);
  import mm_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  typedef struct packed {
    logic             first;   // first product of a dot product
    logic             fin;     // final product of a dot product
    logic             last_el; // final result element
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  logic [VAL_W-1:0] a_mem [DEPTH];
  logic [VAL_W-1:0] b_mem [DEPTH];
  logic [VAL_W-1:0] a_rd_q, b_rd_q;

  state_e           state_q;
  logic [IDX_W-1:0] i_q, j_q, t_q;
  logic [IDX_W-1:0] m_last, n_last, k_last;
  logic [CNT_W-1:0] a_lin, b_lin;
  logic             issue;
  tag_t             tag;

  logic             s1_vld_q, s2_vld_q;
  tag_t             s1_tag_q, s2_tag_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q, acc_d;

  logic             res_vld_q, last_q;
  logic [SUM_W-1:0] sum_q;
  logic [IDX_W-1:0] row_q, col_q;

  assign m_last = IDX_W'(dims_i.m - DIM_W'(1));
  assign n_last = IDX_W'(dims_i.n - DIM_W'(1));
  assign k_last = IDX_W'(dims_i.k - DIM_W'(1));

  // row-major addresses of A[i][t] and B[t][j]
  assign a_lin = CNT_W'(i_q) * CNT_W'(dims_i.k) + CNT_W'(t_q);
  assign b_lin = CNT_W'(t_q) * CNT_W'(dims_i.n) + CNT_W'(j_q);

  assign issue       = (state_q == ST_RUN);
  assign tag.first   = (t_q == '0);
  assign tag.fin     = (t_q == k_last);
  assign tag.last_el = (i_q == m_last) && (j_q == n_last);
  assign tag.row     = i_q;
  assign tag.col     = j_q;

  // store writes and registered reads
  always_ff @(posedge clk_i) begin
    if (load_i.a_we) begin
      a_mem[load_i.addr] <= load_i.data;
    end
    if (load_i.b_we) begin
      b_mem[load_i.addr] <= load_i.data;
    end
    a_rd_q <= a_mem[a_lin[ADDR_W-1:0]];
    b_rd_q <= b_mem[b_lin[ADDR_W-1:0]];
  end

  // step t, then j, then i; stop after the last product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      t_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          i_q <= '0;
          j_q <= '0;
          t_q <= '0;
          if (load_i.go) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (t_q != k_last) begin
            t_q <= t_q + IDX_W'(1);
          end else begin
            t_q <= '0;
            if (j_q != n_last) begin
              j_q <= j_q + IDX_W'(1);
            end else begin
              j_q <= '0;
              if (i_q != m_last) begin
                i_q <= i_q + IDX_W'(1);
              end else begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // pipeline valid flags and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= issue;
      s2_vld_q  <= s1_vld_q;
      res_vld_q <= s2_vld_q && s2_tag_q.fin;
    end
  end

  // accumulate the running dot product
  assign acc_d = (s2_tag_q.first ? '0 : acc_q) + SUM_W'(prod_q);

  // multiply, accumulate and hold the finished sum
  always_ff @(posedge clk_i) begin
    s1_tag_q <= tag;
    s2_tag_q <= s1_tag_q;
    prod_q   <= $signed(a_rd_q) * $signed(b_rd_q);
    if (s2_vld_q) begin
      acc_q <= acc_d;
    end
    if (s2_vld_q && s2_tag_q.fin) begin
      sum_q  <= acc_d;
      row_q  <= s2_tag_q.row;
      col_q  <= s2_tag_q.col;
      last_q <= s2_tag_q.last_el;
    end
  end

  assign result_valid_o = res_vld_q;
  assign sum_o          = sum_q;
  assign row_o          = row_q;
  assign col_o          = col_q;
  assign last_o         = last_q;
  assign done_o         = res_vld_q && last_q;

endmodule

`default_nettype wire

### hw/rtl/matrix_multiply.sv
// Top level of the fixed-point matrix multiply: register port, load control, datapath.
// Depends on mm_pkg, mm_cfg, mm_ctrl and mm_dpath.
`default_nettype none

// While busy is low, start with mode_i and value_i is taken at every clock
// edge. The load that completes both matrices raises busy; the block then
// runs one multiply-accumulate per cycle through a single shared multiplier
// fed by the two element memories, and emits the M*N results in row-major
// order. Busy drops in the cycle after the strobe of the result marked
// last. Each result is valid for one cycle only and must be taken then.
// Size registers may be written only while busy is low.
module matrix_multiply (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        mode_i,
  input  wire logic [mm_pkg::VAL_W-1:0]    value_i,
  output logic                             result_valid_o,
  output logic      [mm_pkg::SUM_W-1:0]    sum_o,
  output logic      [mm_pkg::IDX_W-1:0]    row_o,
  output logic      [mm_pkg::IDX_W-1:0]    col_o,
  output logic                             last_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mm_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mm_pkg::PDATA_W-1:0]  pwdata,
  output logic      [mm_pkg::PDATA_W-1:0]  prdata,
  output logic                             pready
);
  import mm_pkg::*;

  dims_t dims;
  load_t load;
  logic  done;

  mm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims_o  (dims)
  );

  mm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .mode_i  (mode_i),
    .value_i (value_i),
    .dims_i  (dims),
    .done_i  (done),
    .load_o  (load)
  );

  mm_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .dims_i         (dims),
    .result_valid_o (result_valid_o),
    .sum_o          (sum_o),
    .row_o          (row_o),
    .col_o          (col_o),
    .last_o         (last_o),
    .done_o         (done)
  );

endmodule

`default_nettype wire

### hw/rtl/mm_checker.sv
// Port-level checks of the matrix multiply, bound to the top level.
// Depends only on the ports of matrix_multiply.
`default_nettype none

module mm_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic result_valid_o,
  input wire logic last_o,
  input wire logic pready
);

  // results appear only while a multiply runs
  a_res_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while not busy");

  // busy rises only after an accepted transaction
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted transaction");

  // busy ends right after the last result
  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(result_valid_o && last_o))
    else $error("busy fell before the last result");

  // the last result closes the matrix
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> (!result_valid_o && !busy))
    else $error("activity after the last result");

  // the register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);

`default_nettype wire
